// ----- rtl/mdbbl_pkg.sv -----
// Shared types and codes for the bill-validator link master.
`timescale 1ns / 1ps

package mdbbl_pkg;

    typedef enum logic [2:0] {
        CMD_SEND_BYTE  = 3'd0,
        CMD_END_FRAME  = 3'd1,
        CMD_START_RX   = 3'd2,
        CMD_RX_WORD    = 3'd3,
        CMD_MS_TICK    = 3'd4
    } mdbbl_cmd_t;

    typedef enum logic {
        KIND_TX_WORD   = 1'b0,
        KIND_RESPONSE  = 1'b1
    } mdbbl_kind_t;

    localparam logic [7:0] ACK_BYTE = 8'h00;

    typedef struct packed {
        logic [2:0]  command;
        logic [8:0]  data_word;
        logic [5:0]  resp_len;
        logic [15:0] timeout_ms;
        logic        require_full;
    } mdbbl_in_t;

    typedef struct packed {
        logic        result_kind;
        logic [8:0]  tx_word;
        logic        success;
        logic        timed_out;
        logic        checksum_ok;
        logic        is_ack;
        logic [5:0]  length;
        logic        bill_accepted;
        logic [2:0]  bill_route;
        logic [3:0]  bill_denom;
        logic [7:0]  status_byte;
    } mdbbl_out_t;

    // Response summary handed from the receive side to the top level
    typedef struct packed {
        logic        done;
        logic        success;
        logic        timed_out;
        logic        checksum_ok;
        logic        is_ack;
        logic [5:0]  length;
        logic [8:0]  first_word;
    } mdbbl_rx_res_t;

    // Transmit side status
    typedef struct packed {
        logic        emit;
        logic [8:0]  word;
    } mdbbl_tx_res_t;

endpackage

// ----- rtl/mdbbl_tx.sv -----
// Transmit framer: address mark on first byte, running checksum, end-of-frame word.
`timescale 1ns / 1ps

module mdbbl_tx (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  mdbbl_pkg::mdbbl_in_t  item,
    output mdbbl_pkg::mdbbl_tx_res_t res
);
    import mdbbl_pkg::*;

    logic [7:0] sum_reg, sum_next;
    logic       first_reg, first_next;
    logic [7:0] byte_in;

    assign byte_in = item.data_word[7:0];

    always_comb
    begin
        sum_next   = sum_reg;
        first_next = first_reg;
        res.emit   = 1'b0;
        res.word   = '0;
        unique case (item.command)
            CMD_SEND_BYTE:
            begin
                res.emit   = 1'b1;
                res.word   = {first_reg, byte_in};
                first_next = 1'b0;
                sum_next   = sum_reg + byte_in;
            end
            CMD_END_FRAME:
            begin
                res.emit   = 1'b1;
                res.word   = {1'b0, sum_reg};
                sum_next   = '0;
                first_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (fire)
        begin
            sum_reg   <= sum_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- rtl/mdbbl_rx.sv -----
// Response receiver: word count, checksum, timeout and completion summary.
`timescale 1ns / 1ps

module mdbbl_rx #(
    parameter int MAX_RESPONSE_WORDS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  mdbbl_pkg::mdbbl_in_t  item,
    output mdbbl_pkg::mdbbl_rx_res_t res
);
    import mdbbl_pkg::*;

    localparam int CW = $clog2(MAX_RESPONSE_WORDS + 1);

    logic          active_reg, active_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] expected_reg, expected_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    last_reg, last_next;
    logic [8:0]    first_reg, first_next;
    logic [15:0]   timer_reg, timer_next;
    logic          full_req_reg, full_req_next;

    logic [5:0]    len_in;
    logic          have;

    assign len_in = item.resp_len;

    always_comb
    begin
        active_next   = active_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        first_next    = first_reg;
        timer_next    = timer_reg;
        full_req_next = full_req_reg;
        res.done      = 1'b0;
        res.timed_out = 1'b0;
        unique case (item.command)
            CMD_START_RX:
            begin
                if (len_in == '0)
                    expected_next = CW'(1);
                else if (int'(len_in) > MAX_RESPONSE_WORDS)
                    expected_next = CW'(MAX_RESPONSE_WORDS);
                else
                    expected_next = CW'(len_in);
                active_next   = 1'b1;
                count_next    = '0;
                sum_next      = '0;
                last_next     = '0;
                first_next    = '0;
                timer_next    = item.timeout_ms;
                full_req_next = item.require_full;
            end
            CMD_RX_WORD:
            begin
                if (active_reg)
                begin
                    if (count_reg == '0)
                        first_next = item.data_word;
                    else
                        sum_next = sum_reg + last_reg;
                    last_next  = item.data_word[7:0];
                    count_next = count_reg + 1'b1;
                    if (count_next >= expected_reg)
                    begin
                        res.done    = 1'b1;
                        active_next = 1'b0;
                    end
                end
            end
            CMD_MS_TICK:
            begin
                if (active_reg && timer_reg != '0)
                begin
                    timer_next = timer_reg - 1'b1;
                    if (timer_next == '0)
                    begin
                        res.done      = 1'b1;
                        res.timed_out = 1'b1;
                        active_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Summary is taken from the post-update values
        have            = (count_next != '0);
        res.success     = full_req_reg ? (count_next >= expected_next) : 1'b1;
        res.checksum_ok = have && (sum_next == last_next);
        res.first_word  = have ? first_next : '0;
        res.is_ack      = have && (first_next[7:0] == ACK_BYTE);
        res.length      = 6'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            count_reg    <= '0;
            expected_reg <= CW'(1);
            sum_reg      <= '0;
            last_reg     <= '0;
            first_reg    <= '0;
            timer_reg    <= '0;
            full_req_reg <= 1'b1;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            count_reg    <= count_next;
            expected_reg <= expected_next;
            sum_reg      <= sum_next;
            last_reg     <= last_next;
            first_reg    <= first_next;
            timer_reg    <= timer_next;
            full_req_reg <= full_req_next;
        end
    end

endmodule

// ----- rtl/mdb_bill_link_master.sv -----
// Path: an accepted item waits in the input register; its result, if any, is
// loaded into the result register and offered from there.
// Throughput: one item per cycle; the only hold-up is a stalled result register
// while the item in the input register produces a result.
// Reset (rst_n, async, active low): both channels empty, transmit armed for an
// address byte with checksum 0, no response active, expected length 1.
`timescale 1ns / 1ps

module mdb_bill_link_master #(
    parameter int MAX_RESPONSE_WORDS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mdbbl_pkg::mdbbl_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mdbbl_pkg::mdbbl_out_t  out_data
);
    import mdbbl_pkg::*;

    // Input register: holds one item until it can be processed
    logic        in_vld_reg, in_vld_next;
    mdbbl_in_t   in_reg, in_next;

    // Result register
    logic        out_vld_reg, out_vld_next;
    mdbbl_out_t  out_reg, out_next;

    mdbbl_tx_res_t tx_res;
    mdbbl_rx_res_t rx_res;

    logic has_result;
    logic advance;

    // The held item commits its state update when it moves on. An item that
    // yields no result can always move on; one with a result needs room in
    // the result register.
    assign has_result = tx_res.emit | rx_res.done;
    assign advance    = in_vld_reg && (!out_vld_reg || out_ready || !has_result);
    assign in_ready   = !in_vld_reg || advance;

    mdbbl_tx u_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_reg),
        .res   (tx_res)
    );

    mdbbl_rx #(
        .MAX_RESPONSE_WORDS (MAX_RESPONSE_WORDS)
    ) u_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_reg),
        .res   (rx_res)
    );

    always_comb
    begin
        in_next     = in_reg;
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
        begin
            in_next     = in_data;
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    // Result formatting: transmit words carry zeros in every response field,
    // response summaries carry a zero transmit word.
    always_comb
    begin
        out_next = '0;
        if (tx_res.emit)
        begin
            out_next.result_kind = KIND_TX_WORD;
            out_next.tx_word     = tx_res.word;
        end
        else
        begin
            out_next.result_kind   = KIND_RESPONSE;
            out_next.success       = rx_res.success;
            out_next.timed_out     = rx_res.timed_out;
            out_next.checksum_ok   = rx_res.checksum_ok;
            out_next.is_ack        = rx_res.is_ack;
            out_next.length        = rx_res.length;
            out_next.bill_accepted = rx_res.first_word[7];
            out_next.bill_route    = rx_res.first_word[6:4];
            out_next.bill_denom    = rx_res.first_word[3:0];
            out_next.status_byte   = rx_res.first_word[7:0];
        end

        out_vld_next = out_vld_reg;
        if (advance && has_result)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
        if (advance && has_result)
            out_reg <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // A command is either transmit or receive side, never both
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(tx_res.emit && rx_res.done))
        else $error("transmit and response results in the same item");

    // A held item that cannot move on keeps its slot and its contents
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_reg)))
        else $error("stalled item lost from input register");

    // Transmit words never carry response flags
    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.result_kind == KIND_TX_WORD) |->
            (!out_reg.success && !out_reg.timed_out && out_reg.length == '0))
        else $error("transmit item carries response fields");

    // Result register filled exactly when a producing item moves on
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result) |=> out_vld_reg)
        else $error("result dropped");

endmodule

// ----- bench/mdbbl_link_checker.sv -----
// Checker for the bill-validator link master: predicts each result and compares it.
`timescale 1ns / 1ps

module mdbbl_link_checker #(
    parameter int MAX_RESPONSE_WORDS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  mdbbl_pkg::mdbbl_in_t   in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  mdbbl_pkg::mdbbl_out_t  out_data,
    output int unsigned            failures,
    output int unsigned            pending
);

    import mdbbl_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // transmit side
    logic [7:0]  tx_csum;
    logic        addr_next;
    // receive side
    logic        resp_open;
    logic [5:0]  resp_count;
    logic [5:0]  resp_target;
    logic [7:0]  resp_sum;      // low bytes of all words but the latest
    logic [7:0]  resp_last;
    logic [8:0]  resp_first;
    logic [15:0] resp_timer;
    logic        resp_strict;

    mdbbl_out_t  due_results[$];

    task automatic note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t mismatch:%s", $time, what);
    endtask

    // Response finished: build the summary and decode of the first word.
    task automatic close_response(input logic by_timer);
        mdbbl_out_t r;
        logic       have;
        logic [8:0] fw;
        have = (resp_count != 0);
        fw = have ? resp_first : '0;
        r = '0;
        r.result_kind   = KIND_RESPONSE;
        r.success       = resp_strict ? (resp_count >= resp_target) : 1'b1;
        r.timed_out     = by_timer;
        r.checksum_ok   = have && (resp_sum == resp_last);
        r.is_ack        = have && (fw[7:0] == ACK_BYTE);
        r.length        = resp_count;
        r.bill_accepted = fw[7];
        r.bill_route    = fw[6:4];
        r.bill_denom    = fw[3:0];
        r.status_byte   = fw[7:0];
        due_results.push_back(r);
        resp_open = 1'b0;
    endtask

    task automatic predict_link(input mdbbl_in_t item);
        mdbbl_out_t r;
        int         target;
        r = '0;
        case (item.command)
            CMD_SEND_BYTE:
            begin
                r.result_kind = KIND_TX_WORD;
                r.tx_word = {addr_next, item.data_word[7:0]};
                addr_next = 1'b0;
                tx_csum = tx_csum + item.data_word[7:0];
                due_results.push_back(r);
            end
            CMD_END_FRAME:
            begin
                r.result_kind = KIND_TX_WORD;
                r.tx_word = {1'b0, tx_csum};
                tx_csum = '0;
                addr_next = 1'b1;
                due_results.push_back(r);
            end
            CMD_START_RX:
            begin
                // any open response is dropped silently
                target = item.resp_len;
                if (target == 0)
                    target = 1;
                if (target > MAX_RESPONSE_WORDS)
                    target = MAX_RESPONSE_WORDS;
                resp_target = 6'(target);
                resp_open   = 1'b1;
                resp_count  = '0;
                resp_sum    = '0;
                resp_last   = '0;
                resp_first  = '0;
                resp_timer  = item.timeout_ms;
                resp_strict = item.require_full;
            end
            CMD_RX_WORD:
            begin
                if (resp_open)
                begin
                    if (resp_count == 0)
                        resp_first = item.data_word;
                    else
                        resp_sum = resp_sum + resp_last;
                    resp_last = item.data_word[7:0];
                    resp_count = resp_count + 6'd1;
                    if (resp_count >= resp_target)
                        close_response(1'b0);
                end
            end
            CMD_MS_TICK:
            begin
                // zero timer means no timeout
                if (resp_open && resp_timer != 0)
                begin
                    resp_timer = resp_timer - 16'd1;
                    if (resp_timer == 0)
                        close_response(1'b1);
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic check_result(input mdbbl_out_t got);
        mdbbl_out_t want;
        string      diff;
        if (due_results.size() == 0)
        begin
            note_failure($sformatf(" result %h with nothing due", got));
        end
        else
        begin
            want = due_results.pop_front();
            diff = "";
            if (got.result_kind !== want.result_kind)
                diff = {diff, $sformatf(" result_kind %h/%h", want.result_kind, got.result_kind)};
            if (got.tx_word !== want.tx_word)
                diff = {diff, $sformatf(" tx_word %h/%h", want.tx_word, got.tx_word)};
            if (got.success !== want.success)
                diff = {diff, $sformatf(" success %h/%h", want.success, got.success)};
            if (got.timed_out !== want.timed_out)
                diff = {diff, $sformatf(" timed_out %h/%h", want.timed_out, got.timed_out)};
            if (got.checksum_ok !== want.checksum_ok)
                diff = {diff, $sformatf(" checksum_ok %h/%h", want.checksum_ok, got.checksum_ok)};
            if (got.is_ack !== want.is_ack)
                diff = {diff, $sformatf(" is_ack %h/%h", want.is_ack, got.is_ack)};
            if (got.length !== want.length)
                diff = {diff, $sformatf(" length %0d/%0d", want.length, got.length)};
            if (got.bill_accepted !== want.bill_accepted)
                diff = {diff, $sformatf(" bill_accepted %h/%h",
                                        want.bill_accepted, got.bill_accepted)};
            if (got.bill_route !== want.bill_route)
                diff = {diff, $sformatf(" bill_route %h/%h",
                                        want.bill_route, got.bill_route)};
            if (got.bill_denom !== want.bill_denom)
                diff = {diff, $sformatf(" bill_denom %h/%h", want.bill_denom, got.bill_denom)};
            if (got.status_byte !== want.status_byte)
                diff = {diff, $sformatf(" status_byte %h/%h", want.status_byte, got.status_byte)};
            if (diff != "")
                note_failure({" (expected/actual)", diff});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_csum     = '0;
            addr_next   = 1'b1;
            resp_open   = 1'b0;
            resp_count  = '0;
            resp_target = 6'd1;
            resp_sum    = '0;
            resp_last   = '0;
            resp_first  = '0;
            resp_timer  = '0;
            resp_strict = 1'b1;
            due_results.delete();
            failures    = 0;
            pending     = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_link(in_data);
            if (out_valid && out_ready)
                check_result(out_data);
            pending = due_results.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the link master bench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

    import mdbbl_pkg::*;

    localparam int          ITEM_TARGET   = 1000;
    localparam int          QUIET_LIMIT   = 1000;  // cycles with no item moving on either side
    localparam int          SETTLE_CYCLES = 8;     // comfortably past the input and result registers
    localparam int          PHASE_ITEMS   = 200;   // sender drains the block after each phase
    localparam logic [2:0]  CMD_CODE_MAX  = 3'd7;  // codes above CMD_MS_TICK are undefined

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    mdbbl_in_t   in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    mdbbl_out_t  out_data;

    int unsigned failures;
    int unsigned pending;

    // sender pacing
    int          burst_left = 0;
    int          gap_max = 4;
    int          useful_items = 0;

    // receiver pacing
    ready_style_t ready_style = READY_ALWAYS;
    int          style_left = 0;
    int          stride = 2;
    int          beat = 0;

    int unsigned quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    mdb_bill_link_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mdbbl_link_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .failures  (failures),
        .pending   (pending)
    );

    // Receiver: every so often pick a new stall style and hold it for a stretch.
    // Always-ready stretches give full-rate runs; sparse ones back the pipe up
    // so the input side sees in_ready drop.
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            ready_style = ready_style_t'($urandom_range(3, 0));
            style_left  = $urandom_range(150, 20);
            stride      = $urandom_range(5, 2);
        end
        else
        begin
            style_left--;
        end
        beat++;
        case (ready_style)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_COIN:     out_ready <= 1'($urandom_range(1, 0));
            READY_SPARSE:   out_ready <= ($urandom_range(3, 0) == 0);
            default:        out_ready <= ((beat % stride) == 0);
        endcase
    end

    // Watchdog: a correct block never sits this long with nothing moving.
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    // Item with the given command and word; fields the command does not use
    // get random values so they are shown to be ignored.
    function automatic mdbbl_in_t shaped(input logic [2:0] cmd, input logic [8:0] word);
        mdbbl_in_t it;
        it.command      = cmd;
        it.data_word    = word;
        it.resp_len     = 6'($urandom_range(63, 0));
        it.timeout_ms   = 16'($urandom_range(65535, 0));
        it.require_full = 1'($urandom_range(1, 0));
        return it;
    endfunction

    function automatic mdbbl_in_t arm(input logic [5:0] len, input logic [15:0] tmo,
                                      input logic full_mode);
        mdbbl_in_t it;
        it = shaped(CMD_START_RX, 9'($urandom_range(511, 0)));
        it.resp_len     = len;
        it.timeout_ms   = tmo;
        it.require_full = full_mode;
        return it;
    endfunction

    // Offer one item and hold it until accepted. Bursts of random length are
    // separated by random gaps; gap_max of 0 gives back-to-back items.
    task automatic put(input mdbbl_in_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(16, 1);
        end
        burst_left--;
        @(negedge clk);
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender holds off until every predicted result has been seen.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int         c;
        int         len;
        int         tmo;
        int         eff;
        int         words;
        int         left;
        int         style;
        int         n;
        int         phase;
        int         next_drain;
        logic       full_mode;
        logic [7:0] sum;
        logic [8:0] w;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // tick and received word with no response open are dropped
        put(shaped(CMD_MS_TICK, 9'h1FF));
        put(shaped(CMD_RX_WORD, 9'h0A5));
        // undefined command codes
        for (c = int'(CMD_MS_TICK) + 1; c <= int'(CMD_CODE_MAX); c++)
            put(shaped(3'(c), 9'($urandom_range(511, 0))));
        // end of frame with nothing sent gives checksum zero
        put(shaped(CMD_END_FRAME, 9'h1FF));
        // bit 8 of a byte to send is not passed on; first byte takes the address mark
        put(shaped(CMD_SEND_BYTE, 9'h1FF));
        put(shaped(CMD_SEND_BYTE, 9'h000));
        put(shaped(CMD_SEND_BYTE, 9'h0AA));
        put(shaped(CMD_END_FRAME, 9'h000));
        // length 0 read as 1, no timeout; ACK word with bit 8 set
        put(arm(6'd0, 16'd0, 1'b1));
        put(shaped(CMD_RX_WORD, 9'h100));
        // oversize length saturates; empty response times out in short mode
        put(arm(6'd63, 16'd2, 1'b0));
        put(shaped(CMD_MS_TICK, 9'h000));
        put(shaped(CMD_MS_TICK, 9'h000));
        // empty response in full mode fails
        put(arm(6'd2, 16'd1, 1'b1));
        put(shaped(CMD_MS_TICK, 9'h000));
        // restart while a response is open drops the old one
        put(arm(6'd3, 16'd0, 1'b1));
        put(shaped(CMD_RX_WORD, 9'h1FF));
        put(arm(6'd2, 16'hFFFF, 1'b1));
        put(shaped(CMD_RX_WORD, 9'h0F5));
        put(shaped(CMD_RX_WORD, 9'h1F5));
        // short response ended by timeout
        put(arm(6'd5, 16'd3, 1'b0));
        put(shaped(CMD_RX_WORD, 9'h180));
        repeat (3) put(shaped(CMD_MS_TICK, 9'($urandom_range(511, 0))));
        drain();

        // ---- random part ----
        // Mostly well-formed frames and responses, with a tenth of plain noise.
        phase = 0;
        next_drain = PHASE_ITEMS;
        while (useful_items < ITEM_TARGET)
        begin
            if (useful_items >= next_drain)
            begin
                drain();
                next_drain += PHASE_ITEMS;
                phase++;
                // every third phase runs the sender flat out
                gap_max = (phase % 3 == 1) ? 0 : $urandom_range(8, 1);
            end
            case ($urandom_range(9, 0))
                0:
                begin
                    // noise: any command, any field values
                    c = $urandom_range(int'(CMD_CODE_MAX), 0);
                    put(shaped(3'(c), 9'($urandom_range(511, 0))));
                    if (c < int'(CMD_RX_WORD))
                        useful_items++;
                end
                1, 2, 3:
                begin
                    // transmit frame, usually closed by its checksum
                    n = $urandom_range(6, 0);
                    repeat (n)
                        put(shaped(CMD_SEND_BYTE, 9'($urandom_range(511, 0))));
                    useful_items += n;
                    if ($urandom_range(9, 0) != 0)
                    begin
                        put(shaped(CMD_END_FRAME, 9'($urandom_range(511, 0))));
                        useful_items++;
                    end
                end
                default:
                begin
                    // response: arm, feed words with ticks in between, then
                    // either complete it, let it time out, or walk away
                    c = $urandom_range(19, 0);
                    if (c == 0)
                        len = 0;
                    else if (c == 1)
                        len = $urandom_range(63, 32);
                    else if (c < 4)
                        len = $urandom_range(31, 9);
                    else
                        len = $urandom_range(8, 1);
                    c = $urandom_range(9, 0);
                    if (c < 2)
                        tmo = 0;
                    else if (c < 8)
                        tmo = $urandom_range(12, 1);
                    else if (c == 8)
                        tmo = $urandom_range(300, 13);
                    else
                        tmo = $urandom_range(65535, 301);
                    full_mode = 1'($urandom_range(1, 0));
                    eff = (len == 0) ? 1 : (len > 32) ? 32 : len;
                    style = $urandom_range(9, 0);
                    words = (style < 6) ? eff : $urandom_range(eff - 1, 0);

                    put(arm(6'(len), 16'(tmo), full_mode));
                    useful_items++;
                    left = tmo;
                    sum = '0;
                    for (c = 0; c < words; c++)
                    begin
                        // keep at least one tick in hand so the timer cannot
                        // expire before the words are in
                        if (left > 1 && $urandom_range(3, 0) == 0)
                        begin
                            put(shaped(CMD_MS_TICK, 9'($urandom_range(511, 0))));
                            left--;
                            useful_items++;
                        end
                        w = 9'($urandom_range(511, 0));
                        // half the time close with a valid checksum
                        if (c == words - 1 && c > 0 && $urandom_range(1, 0) == 1)
                            w[7:0] = sum;
                        sum = sum + w[7:0];
                        put(shaped(CMD_RX_WORD, w));
                        useful_items++;
                    end
                    if (style >= 6 && style < 9 && tmo != 0 && tmo <= 300)
                    begin
                        while (left > 0)
                        begin
                            put(shaped(CMD_MS_TICK, 9'($urandom_range(511, 0))));
                            left--;
                            useful_items++;
                        end
                    end
                end
            endcase
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
